// ===== sv/mtseq_pkg.sv =====
// Package for the melody tone sequencer: widths, command codes, defaults,
// the controller state type and the divider status struct.
// No dependencies.
package mtseq_pkg;

   localparam int ADDR_W = 7;
   localparam int WORD_W = 16;
   localparam int FREQ_W = 11;
   localparam int LEN_W  = 8;
   localparam int DIV_W  = 16;
   localparam int DUR_W  = 6;

   localparam int NOTE_DEPTH_DEFAULT      = 128;
   localparam int CLOCK_NUMERATOR_DEFAULT = 1193181;

   localparam logic [ADDR_W-1:0] LAST_INDEX_RESET = 7'd109;
   localparam logic [FREQ_W-1:0] SILENT_LIMIT     = 11'h012;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIVIDE,
      ST_PUSH
   } ctrl_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== sv/mtseq_ifs.sv =====
// Valid/ready channel interfaces for the request and response transactions.
// Depends on mtseq_pkg for the field widths.
interface mtseq_req_intf
   import mtseq_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [ADDR_W-1:0] note_addr;
   logic [WORD_W-1:0] note_word;

   modport source (output valid, cmd, note_addr, note_word, input ready);
   modport sink   (input valid, cmd, note_addr, note_word, output ready);
endinterface

interface mtseq_rsp_intf
   import mtseq_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             speaker_enable;
   logic [DIV_W-1:0] tone_divisor;
   logic             divisor_loaded;

   modport source (output valid, speaker_enable, tone_divisor, divisor_loaded, input ready);
   modport sink   (input valid, speaker_enable, tone_divisor, divisor_loaded, output ready);
endinterface

// ===== sv/mtseq_divider.sv =====
// Bit-serial restoring divider: a constant numerator divided by a note frequency,
// one quotient bit per cycle through a shift register. Depends on mtseq_pkg.
module mtseq_divider
   import mtseq_pkg::*;
#(
   parameter int NUMERATOR = CLOCK_NUMERATOR_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FREQ_W-1:0] divisor,
   output div_status_type    status,
   output logic [DIV_W-1:0]  quotient
);

   localparam int NW = $clog2(NUMERATOR + 1);
   localparam int CW = $clog2(NW + 1);

   logic [FREQ_W-1:0] rem_ff, rem_in;
   logic [NW-1:0]     quo_ff, quo_in;
   logic [FREQ_W-1:0] den_ff, den_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [FREQ_W:0]   shifted;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = NW'(NUMERATOR);
         den_in  = divisor;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? FREQ_W'(shifted - {1'b0, den_ff}) : FREQ_W'(shifted);
         quo_in = NW'({quo_ff, fits});
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status   = '{busy: busy_ff, done: done_ff};
   assign quotient = DIV_W'(quo_ff);

endmodule

// ===== sv/melody_tone_sequencer_core.sv =====
// Melody tone sequencer: one response transaction for every request transaction. A write
// request stores a note word in the 16-bit note memory (one write port, one registered read
// port) and then goes to the push state. A tick that only counts also goes straight to push.
// A tick that fetches a note takes the registered read data in the fetch state; a silent note
// goes on to push, and a note that loads a tone first passes through the divide state, where
// the bit-serial divider forms the tone divisor one quotient bit per cycle. The next request is
// accepted while a finished response still waits in the output register.
// Depends on mtseq_pkg, mtseq_ifs and mtseq_divider.
module melody_tone_sequencer_core
   import mtseq_pkg::*;
#(
   parameter int NOTE_DEPTH      = NOTE_DEPTH_DEFAULT,
   parameter int CLOCK_NUMERATOR = CLOCK_NUMERATOR_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   mtseq_req_intf.sink         req_bus,
   mtseq_rsp_intf.source       rsp_bus,
   input  logic                csr_wr_en,
   input  logic [ADDR_W-1:0]   csr_wr_data
);

   localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;

   ctrl_state_type state_ff, state_in;

   logic [WORD_W-1:0] note_mem [NOTE_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_ok_ff;

   logic [ADDR_W-1:0] last_index_ff;
   logic [LEN_W-1:0]  tick_count_ff, tick_count_in;
   logic [LEN_W-1:0]  note_length_ff, note_length_in;
   logic [ADDR_W-1:0] play_index_ff, play_index_in;
   logic              speaker_ff, speaker_in;
   logic [DIV_W-1:0]  divisor_ff, divisor_in;
   logic              loaded_ff, loaded_in;

   logic              rsp_valid_ff;
   logic              rsp_speaker_ff;
   logic [DIV_W-1:0]  rsp_divisor_ff;
   logic              rsp_loaded_ff;

   logic              req_fire;
   logic              counting;
   logic              silent;
   logic              push;
   logic              req_ready;
   logic              div_start;
   logic [WORD_W-1:0] fetched;
   logic [FREQ_W-1:0] freq;
   logic [ADDR_W:0]   next_index;
   logic              wr_ok;
   logic              rd_ok;
   div_status_type    div_status;
   logic [DIV_W-1:0]  div_quotient;

   assign req_fire   = req_bus.valid && req_ready;
   assign counting   = tick_count_ff < note_length_ff;
   assign fetched    = rd_ok_ff ? rd_data_ff : '0;
   assign freq       = fetched[WORD_W-1:DUR_W-1];
   assign silent     = freq <= SILENT_LIMIT;
   assign next_index = {1'b0, play_index_ff} + 1'b1;
   assign wr_ok      = 32'(req_bus.note_addr) < 32'(NOTE_DEPTH);
   assign rd_ok      = 32'(play_index_ff) < 32'(NOTE_DEPTH);

   always_ff @(posedge clock) begin
      if (req_fire && req_bus.cmd == CMD_WRITE && wr_ok) begin
         note_mem[AW'(req_bus.note_addr)] <= req_bus.note_word;
      end
      rd_data_ff <= note_mem[AW'(play_index_ff)];
      rd_ok_ff   <= rd_ok;
   end

   mtseq_divider #(
      .NUMERATOR (CLOCK_NUMERATOR)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (freq),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.cmd == CMD_WRITE || counting) begin
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH:  state_in = silent ? ST_PUSH : ST_DIVIDE;
         ST_DIVIDE: if (div_status.done) state_in = ST_PUSH;
         ST_PUSH:   if (push) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      push      = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_FETCH:  div_start = !silent;
         ST_DIVIDE: ;
         ST_PUSH:   push = !rsp_valid_ff || rsp_bus.ready;
         default:   ;
      endcase
   end

   always_comb begin
      tick_count_in  = tick_count_ff;
      note_length_in = note_length_ff;
      play_index_in  = play_index_ff;
      speaker_in     = speaker_ff;
      divisor_in     = divisor_ff;
      loaded_in      = loaded_ff;
      if (req_fire) begin
         loaded_in = 1'b0;
         if (req_bus.cmd == CMD_TICK && counting) begin
            tick_count_in = tick_count_ff + 1'b1;
         end
      end
      if (state_ff == ST_FETCH) begin
         note_length_in = {{(LEN_W-DUR_W){1'b0}}, fetched[DUR_W-1:0]} - 1'b1;
         tick_count_in  = '0;
         play_index_in  = (next_index > {1'b0, last_index_ff}) ? '0
                                                                : next_index[ADDR_W-1:0];
         if (silent) begin
            speaker_in = 1'b0;
         end
      end
      if (state_ff == ST_DIVIDE && div_status.done) begin
         divisor_in = div_quotient;
         speaker_in = 1'b1;
         loaded_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_index_ff  <= LAST_INDEX_RESET;
         tick_count_ff  <= '0;
         note_length_ff <= '0;
         play_index_ff  <= '0;
         speaker_ff     <= 1'b0;
         divisor_ff     <= '0;
         loaded_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tick_count_ff  <= tick_count_in;
         note_length_ff <= note_length_in;
         play_index_ff  <= play_index_in;
         speaker_ff     <= speaker_in;
         divisor_ff     <= divisor_in;
         loaded_ff      <= loaded_in;
         if (csr_wr_en) begin
            last_index_ff <= csr_wr_data;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_speaker_ff <= speaker_ff;
         rsp_divisor_ff <= divisor_ff;
         rsp_loaded_ff  <= loaded_ff;
      end
   end

   assign req_bus.ready          = req_ready;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.speaker_enable = rsp_speaker_ff;
   assign rsp_bus.tone_divisor   = rsp_divisor_ff;
   assign rsp_bus.divisor_loaded = rsp_loaded_ff;

   a_tick_bounded: assert property (@(posedge clock) disable iff (reset)
      tick_count_ff <= note_length_ff)
      else $error("Tick count ran past the note length.");

   a_start_idle_divider: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("Divider started while still busy.");

   a_loaded_speaker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_loaded_ff |-> rsp_speaker_ff)
      else $error("Divisor loaded while the speaker is silenced.");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIVIDE)
      else $error("Divider finished outside the divide state.");

endmodule
